>>> rtl/sm4c_pkg.sv
package sm4c_pkg;

  localparam int MAX_OUT_BYTES = 1024;
  localparam int LEN_W = 11;
  localparam int ROUNDS = 32;
  localparam int RND_W = 5;
  localparam int BLK_W = 7;

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  localparam logic [0:0] ADDR_IV_HIGH = 1'b0;
  localparam logic [0:0] ADDR_IV_LOW  = 1'b1;

  typedef struct packed {
    logic load;
    logic key_step;
    logic blk_start;
    logic enc_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic last_blk;
  } dp_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] tau(input logic [31:0] a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] t_enc(input logic [31:0] a);
    logic [31:0] b;
    b = tau(a);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic logic [31:0] t_key(input logic [31:0] a);
    logic [31:0] b;
    b = tau(a);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  function automatic logic [31:0] round_const(input logic [RND_W-1:0] i);
    logic [31:0] c;
    logic [7:0] base;
    base = {1'b0, i, 2'b00};
    for (int j = 0; j < 4; j++) begin
      c[31-8*j -: 8] = 8'((base + 8'(j)) * 8'd7);
    end
    return c;
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

>>> rtl/sm4c_ctrl.sv
module sm4c_ctrl
  import sm4c_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    out_taken,
  input  logic    out_full,
  input  dp_sts_t sts,
  output logic    busy,
  output dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    IDLE = 5'b00001,
    KEY  = 5'b00010,
    INIT = 5'b00100,
    ENC  = 5'b01000,
    EMIT = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [RND_W-1:0] rnd, rnd_next;

  always_comb begin
    state_next = state;
    rnd_next = rnd;
    cmd = '0;
    unique case (state)
      IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          rnd_next = '0;
          state_next = KEY;
        end
      end
      KEY: begin
        cmd.key_step = 1'b1;
        rnd_next = rnd + 1'b1;
        if (rnd == RND_W'(ROUNDS - 1)) state_next = INIT;
      end
      INIT: begin
        cmd.blk_start = 1'b1;
        state_next = ENC;
      end
      ENC: begin
        cmd.enc_step = 1'b1;
        rnd_next = rnd + 1'b1;
        if (rnd == RND_W'(ROUNDS - 1)) state_next = EMIT;
      end
      EMIT: begin
        if (!out_full || out_taken) begin
          cmd.out_load = 1'b1;
          state_next = sts.last_blk ? IDLE : INIT;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      rnd <= '0;
    end else begin
      state <= state_next;
      rnd <= rnd_next;
    end
  end

  assign busy = (state != IDLE);

endmodule

>>> rtl/sm4c_datapath.sv
module sm4c_datapath
  import sm4c_pkg::*;
(
  input  logic             clk,
  input  logic [4:0]       rnd,
  input  dp_cmd_t          cmd,
  input  logic [63:0]      key_high,
  input  logic [63:0]      key_low,
  input  logic [31:0]      tweak,
  input  logic [LEN_W-1:0] out_bytes,
  input  logic [63:0]      iv_high,
  input  logic [63:0]      iv_low,
  output dp_sts_t          sts,
  output logic [63:0]      res_high,
  output logic [63:0]      res_low,
  output logic [4:0]       res_valid,
  output logic             res_last
);

  logic [31:0] rk [ROUNDS];
  logic [31:0] k0, k1, k2, k3;
  logic [31:0] x0, x1, x2, x3;
  logic [LEN_W-1:0] remain;
  logic [31:0] ctr;
  logic [31:0] lo_upper;
  logic [31:0] kn, xn;

  assign kn = k0 ^ t_key(k1 ^ k2 ^ k3 ^ round_const(rnd));
  assign xn = x0 ^ t_enc(x1 ^ x2 ^ x3 ^ rk[rnd]);
  assign sts.last_blk = (remain <= LEN_W'(16));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k0 <= key_high[63:32] ^ FK0;
      k1 <= key_high[31:0] ^ FK1;
      k2 <= key_low[63:32] ^ FK2;
      k3 <= key_low[31:0] ^ FK3;
      remain <= (out_bytes > LEN_W'(MAX_OUT_BYTES)) ? LEN_W'(MAX_OUT_BYTES) : out_bytes;
      ctr <= bswap(iv_high[63:32]);
      lo_upper <= bswap(bswap(iv_low[31:0]) + tweak);
    end
    if (cmd.key_step) begin
      rk[rnd] <= kn;
      k0 <= k1; k1 <= k2; k2 <= k3; k3 <= kn;
    end
    if (cmd.blk_start) begin
      x0 <= bswap(ctr);
      x1 <= iv_high[31:0];
      x2 <= iv_low[63:32];
      x3 <= lo_upper;
    end
    if (cmd.enc_step) begin
      x0 <= x1; x1 <= x2; x2 <= x3; x3 <= xn;
    end
    if (cmd.out_load) begin
      res_high <= {x3, x2};
      res_low <= {x1, x0};
      res_valid <= sts.last_blk ? 5'(remain) : 5'd16;
      res_last <= sts.last_blk;
      remain <= remain - LEN_W'(16);
      ctr <= ctr + 32'd1;
    end
  end

endmodule

>>> rtl/sm4_ctr_keystream_generator.sv
// The key schedule runs first; then each 16-byte block passes INIT, the ENC rounds and EMIT to the output register.
// One request is processed at a time by the single iterated round unit; EMIT waits while the output register is full.
// A length of zero is taken at once, runs no key schedule and gives no word.
// Next request is taken once the last block is loaded into the output register.
// Reset (rst, synchronous) clears the controller, output valid and IV registers.
module sm4_ctr_keystream_generator
  import sm4c_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] key_high,
  input  logic [63:0] key_low,
  input  logic [31:0] tweak,
  input  logic [10:0] out_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] block_high,
  output logic [63:0] block_low,
  output logic [4:0]  valid_bytes,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] iv_high, iv_low;
  logic busy, start, out_taken, zero_len;
  dp_cmd_t cmd, cmd_c;
  dp_sts_t sts;
  logic [4:0] rnd;
  logic [4:0] rnd_q;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? iv_low : iv_high;
  assign zero_len = (out_bytes == 11'd0);
  assign in_stall = busy;
  assign start = in_valid && !busy && !zero_len;
  assign out_taken = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv_high <= '0;
      iv_low <= '0;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      unique case (paddr[3])
        ADDR_IV_HIGH: iv_high <= pwdata;
        ADDR_IV_LOW:  iv_low <= pwdata;
        default: ;
      endcase
    end
  end

  sm4c_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .out_taken(out_taken),
    .out_full(out_valid), .sts(sts), .busy(busy), .cmd(cmd_c)
  );

  always_ff @(posedge clk) begin
    if (rst) rnd_q <= '0;
    else if (cmd_c.load || cmd_c.blk_start) rnd_q <= '0;
    else if (cmd_c.key_step || cmd_c.enc_step) rnd_q <= rnd_q + 1'b1;
  end

  assign rnd = rnd_q;
  assign cmd = cmd_c;

  sm4c_datapath u_dp (
    .clk(clk), .rnd(rnd), .cmd(cmd), .key_high(key_high), .key_low(key_low),
    .tweak(tweak), .out_bytes(out_bytes), .iv_high(iv_high), .iv_low(iv_low),
    .sts(sts), .res_high(block_high), .res_low(block_low),
    .res_valid(valid_bytes), .res_last(last)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_taken) out_valid <= 1'b0;
  end

endmodule

>>> rtl/sm4c_checker.sv
module sm4c_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] valid_bytes,
  input logic       last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(valid_bytes) && $stable(last))
    else $error("stalled word changed");

  a_vb: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> valid_bytes != 5'd0 && valid_bytes <= 5'd16)
    else $error("valid_bytes out of range");

  a_part: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_bytes != 5'd16 |-> last)
    else $error("partial block not last");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("reset state wrong");

endmodule

bind sm4_ctr_keystream_generator sm4c_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .valid_bytes(valid_bytes), .last(last)
);
